/* rtl/assert_macros.svh */
// Assertion macros used by the lightmap combine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/lmc_pkg.sv */
// Constants and types for the lightmap texel combine block.
package lmc_pkg;

    localparam int NUM_MAPS  = 4;
    localparam int NUM_CH    = 3;
    localparam int SMP_W     = 8;
    localparam int SCL_W     = 16;
    localparam int RGB_W     = NUM_CH * SMP_W;
    localparam int CFG_W     = NUM_CH * SCL_W;
    localparam int FRAC_BITS = 12;
    localparam int PROD_W    = SMP_W + SCL_W;
    localparam int ACC_W     = PROD_W + $clog2(NUM_MAPS);
    localparam int DYN_W     = 28;
    localparam int SUM_W     = DYN_W + 1;
    localparam int CHN_W     = DYN_W - FRAC_BITS;
    localparam int Q_W       = 8;
    localparam int NUM_W     = CHN_W + Q_W;
    localparam int CNT_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int BYTE_MAX  = 255;
    localparam int LATENCY   = 5 + Q_W;

    localparam logic [CFG_IDX_W-1:0] REG_FULL_BRIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAP0_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAP1_SCALE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAP2_SCALE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAP3_SCALE  = 3'd5;

    typedef logic [PROD_W-1:0]       prod_t;
    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic [CHN_W-1:0]        chn_t;
    typedef logic [NUM_W-1:0]        num_t;
    typedef logic [Q_W-1:0]          quo_t;

endpackage

/* rtl/lightmap_texel_combine_rgba.sv */
// Lightmap texel combine: style maps times scales, dynamic add, clamp, rescale to RGBA.
// Pipeline: a texel taken while start is high and busy low has its word on the
//   result ports with done high once it has passed 13 register stages.
// Throughput: one texel per cycle; the divider is 8 pipelined one-bit stages, busy stays low.
// Reset (rst_n low, async): all config registers clear to 0 and the pipeline empties.
// The receiver cannot stall; each result word is shown for exactly one cycle.
`include "assert_macros.svh"

module lightmap_texel_combine_rgba (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [lmc_pkg::RGB_W-1:0]            map0_rgb,
    input  logic [lmc_pkg::RGB_W-1:0]            map1_rgb,
    input  logic [lmc_pkg::RGB_W-1:0]            map2_rgb,
    input  logic [lmc_pkg::RGB_W-1:0]            map3_rgb,
    input  logic signed [lmc_pkg::DYN_W-1:0]     dyn_red,
    input  logic signed [lmc_pkg::DYN_W-1:0]     dyn_green,
    input  logic signed [lmc_pkg::DYN_W-1:0]     dyn_blue,
    output logic                                 done,
    output logic [lmc_pkg::SMP_W-1:0]            out_red,
    output logic [lmc_pkg::SMP_W-1:0]            out_green,
    output logic [lmc_pkg::SMP_W-1:0]            out_blue,
    output logic [lmc_pkg::SMP_W-1:0]            out_alpha,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lmc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lmc_pkg::CFG_W-1:0]            cfg_data
);

    localparam int NM  = lmc_pkg::NUM_MAPS;
    localparam int NC  = lmc_pkg::NUM_CH;
    localparam int QW  = lmc_pkg::Q_W;
    localparam int SW  = lmc_pkg::SMP_W;
    localparam int CW  = lmc_pkg::SCL_W;

    // config registers
    logic                          full_bright_reg;
    logic [lmc_pkg::CNT_W-1:0]     map_count_reg;
    logic [lmc_pkg::CFG_W-1:0]     map_scale_reg [NM];

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_bright_reg <= 1'b0;
            map_count_reg   <= '0;
            for (int m = 0; m < NM; m++)
            begin
                map_scale_reg[m] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lmc_pkg::REG_FULL_BRIGHT: full_bright_reg  <= cfg_data[0];
                lmc_pkg::REG_MAP_COUNT:   map_count_reg    <= cfg_data[lmc_pkg::CNT_W-1:0];
                lmc_pkg::REG_MAP0_SCALE:  map_scale_reg[0] <= cfg_data;
                lmc_pkg::REG_MAP1_SCALE:  map_scale_reg[1] <= cfg_data;
                lmc_pkg::REG_MAP2_SCALE:  map_scale_reg[2] <= cfg_data;
                lmc_pkg::REG_MAP3_SCALE:  map_scale_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: per-map, per-channel products
    logic [lmc_pkg::RGB_W-1:0]          rgb_in [NM];
    logic signed [lmc_pkg::DYN_W-1:0]   dyn_in [NC];
    logic [lmc_pkg::CNT_W-1:0]          map_n;
    lmc_pkg::prod_t                     prod_next [NM][NC];
    logic                               vld1_reg, fb1_reg;
    lmc_pkg::prod_t                     prod1_reg [NM][NC];
    logic signed [lmc_pkg::DYN_W-1:0]   dyn1_reg [NC];

    assign rgb_in[0] = map0_rgb;
    assign rgb_in[1] = map1_rgb;
    assign rgb_in[2] = map2_rgb;
    assign rgb_in[3] = map3_rgb;
    assign dyn_in[0] = dyn_red;
    assign dyn_in[1] = dyn_green;
    assign dyn_in[2] = dyn_blue;

    always_comb
    begin
        map_n = (map_count_reg > lmc_pkg::CNT_W'(NM)) ? lmc_pkg::CNT_W'(NM) : map_count_reg;
        for (int m = 0; m < NM; m++)
        begin
            for (int c = 0; c < NC; c++)
            begin
                if (lmc_pkg::CNT_W'(m) < map_n)
                begin
                    prod_next[m][c] = lmc_pkg::PROD_W'(rgb_in[m][SW*c +: SW])
                                    * lmc_pkg::PROD_W'(map_scale_reg[m][CW*c +: CW]);
                end
                else
                begin
                    prod_next[m][c] = '0;
                end
            end
        end
    end

    // stage 2: accumulate and add dynamic light
    lmc_pkg::sum_t                  sum_next [NC];
    logic [lmc_pkg::ACC_W-1:0]      acc_sum [NC];
    logic                           vld2_reg, fb2_reg;
    lmc_pkg::sum_t                  sum2_reg [NC];

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            acc_sum[c] = '0;
            for (int m = 0; m < NM; m++)
            begin
                acc_sum[c] = acc_sum[c] + lmc_pkg::ACC_W'(prod1_reg[m][c]);
            end
            sum_next[c] = $signed({{(lmc_pkg::SUM_W-lmc_pkg::ACC_W){1'b0}}, acc_sum[c]})
                        + $signed({{(lmc_pkg::SUM_W-lmc_pkg::DYN_W){dyn1_reg[c][lmc_pkg::DYN_W-1]}},
                                   dyn1_reg[c]});
        end
    end

    // stage 3: clamp negatives, drop fraction
    lmc_pkg::chn_t                  ch_next [NC];
    logic                           vld3_reg, fb3_reg;
    lmc_pkg::chn_t                  ch3_reg [NC];

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            ch_next[c] = sum2_reg[c][lmc_pkg::SUM_W-1] ? '0
                       : sum2_reg[c][lmc_pkg::FRAC_BITS +: lmc_pkg::CHN_W];
        end
    end

    // stage 4: brightest channel and c*255 dividends
    lmc_pkg::chn_t                  mx_next;
    lmc_pkg::num_t                  num_next [NC];
    logic                           big_next;
    logic                           vld4_reg, fb4_reg, big4_reg;
    lmc_pkg::chn_t                  mx4_reg;
    lmc_pkg::chn_t                  ch4_reg [NC];
    lmc_pkg::num_t                  num4_reg [NC];

    always_comb
    begin
        mx_next = (ch3_reg[0] > ch3_reg[1]) ? ch3_reg[0] : ch3_reg[1];
        if (ch3_reg[2] > mx_next)
        begin
            mx_next = ch3_reg[2];
        end
        big_next = (mx_next > lmc_pkg::CHN_W'(lmc_pkg::BYTE_MAX));
        for (int c = 0; c < NC; c++)
        begin
            num_next[c] = {ch3_reg[c], {QW{1'b0}}} - lmc_pkg::NUM_W'(ch3_reg[c]);
        end
    end

    // divider: one quotient bit per stage, msb first
    logic                           src_vld [QW];
    logic                           src_fb [QW];
    logic                           src_big [QW];
    lmc_pkg::chn_t                  src_mx [QW];
    lmc_pkg::chn_t                  src_ch [QW][NC];
    lmc_pkg::num_t                  src_rem [QW][NC];
    lmc_pkg::quo_t                  src_q [QW][NC];
    lmc_pkg::num_t                  dv_dsr [QW];
    lmc_pkg::num_t                  rem_next [QW][NC];
    lmc_pkg::quo_t                  q_next [QW][NC];
    logic                           dv_vld_reg [QW];
    logic                           dv_fb_reg [QW];
    logic                           dv_big_reg [QW];
    lmc_pkg::chn_t                  dv_mx_reg [QW];
    lmc_pkg::chn_t                  dv_ch_reg [QW][NC];
    lmc_pkg::num_t                  dv_rem_reg [QW][NC];
    lmc_pkg::quo_t                  dv_q_reg [QW][NC];

    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            if (k == 0)
            begin
                src_vld[k] = vld4_reg;
                src_fb[k]  = fb4_reg;
                src_big[k] = big4_reg;
                src_mx[k]  = mx4_reg;
                for (int c = 0; c < NC; c++)
                begin
                    src_ch[k][c]  = ch4_reg[c];
                    src_rem[k][c] = num4_reg[c];
                    src_q[k][c]   = '0;
                end
            end
            else
            begin
                src_vld[k] = dv_vld_reg[k-1];
                src_fb[k]  = dv_fb_reg[k-1];
                src_big[k] = dv_big_reg[k-1];
                src_mx[k]  = dv_mx_reg[k-1];
                for (int c = 0; c < NC; c++)
                begin
                    src_ch[k][c]  = dv_ch_reg[k-1][c];
                    src_rem[k][c] = dv_rem_reg[k-1][c];
                    src_q[k][c]   = dv_q_reg[k-1][c];
                end
            end
            dv_dsr[k] = lmc_pkg::NUM_W'(src_mx[k]) << (QW - 1 - k);
            for (int c = 0; c < NC; c++)
            begin
                q_next[k][c] = src_q[k][c];
                if (src_rem[k][c] >= dv_dsr[k])
                begin
                    rem_next[k][c]         = src_rem[k][c] - dv_dsr[k];
                    q_next[k][c][QW-1-k]   = 1'b1;
                end
                else
                begin
                    rem_next[k][c] = src_rem[k][c];
                end
            end
        end
    end

    // output select
    logic [SW-1:0]                  red_next, green_next, blue_next, alpha_next;
    logic                           done_reg;
    logic [SW-1:0]                  red_reg, green_reg, blue_reg, alpha_reg;

    always_comb
    begin
        if (dv_fb_reg[QW-1])
        begin
            red_next   = SW'(lmc_pkg::BYTE_MAX);
            green_next = SW'(lmc_pkg::BYTE_MAX);
            blue_next  = SW'(lmc_pkg::BYTE_MAX);
            alpha_next = SW'(lmc_pkg::BYTE_MAX);
        end
        else if (dv_big_reg[QW-1])
        begin
            red_next   = dv_q_reg[QW-1][0];
            green_next = dv_q_reg[QW-1][1];
            blue_next  = dv_q_reg[QW-1][2];
            alpha_next = SW'(lmc_pkg::BYTE_MAX);
        end
        else
        begin
            red_next   = dv_ch_reg[QW-1][0][SW-1:0];
            green_next = dv_ch_reg[QW-1][1][SW-1:0];
            blue_next  = dv_ch_reg[QW-1][2][SW-1:0];
            alpha_next = dv_mx_reg[QW-1][SW-1:0];
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            for (int k = 0; k < QW; k++)
            begin
                dv_vld_reg[k] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= start && !busy;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            for (int k = 0; k < QW; k++)
            begin
                dv_vld_reg[k] <= src_vld[k];
            end
            done_reg <= dv_vld_reg[QW-1];
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        fb1_reg <= full_bright_reg;
        for (int c = 0; c < NC; c++)
        begin
            dyn1_reg[c] <= dyn_in[c];
            for (int m = 0; m < NM; m++)
            begin
                prod1_reg[m][c] <= prod_next[m][c];
            end
        end
        fb2_reg <= fb1_reg;
        fb3_reg <= fb2_reg;
        fb4_reg <= fb3_reg;
        big4_reg <= big_next;
        mx4_reg  <= mx_next;
        for (int c = 0; c < NC; c++)
        begin
            sum2_reg[c] <= sum_next[c];
            ch3_reg[c]  <= ch_next[c];
            ch4_reg[c]  <= ch3_reg[c];
            num4_reg[c] <= num_next[c];
        end
        for (int k = 0; k < QW; k++)
        begin
            dv_fb_reg[k]  <= src_fb[k];
            dv_big_reg[k] <= src_big[k];
            dv_mx_reg[k]  <= src_mx[k];
            for (int c = 0; c < NC; c++)
            begin
                dv_ch_reg[k][c]  <= src_ch[k][c];
                dv_rem_reg[k][c] <= rem_next[k][c];
                dv_q_reg[k][c]   <= q_next[k][c];
            end
        end
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
        alpha_reg <= alpha_next;
    end

    assign done      = done_reg;
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;
    assign out_alpha = alpha_reg;

    `ASSERT_IMPL(a_alpha_is_max, done,
        (out_alpha >= out_red) && (out_alpha >= out_green) && (out_alpha >= out_blue))
    `ASSERT_IMPL(a_word_latency, done, $past(start && !busy, lmc_pkg::LATENCY))
    `ASSERT_IMPL(a_div_rem_bound, dv_vld_reg[QW-1] && dv_big_reg[QW-1],
        (lmc_pkg::CHN_W'(dv_rem_reg[QW-1][0]) < dv_mx_reg[QW-1])
        && (lmc_pkg::CHN_W'(dv_rem_reg[QW-1][1]) < dv_mx_reg[QW-1])
        && (lmc_pkg::CHN_W'(dv_rem_reg[QW-1][2]) < dv_mx_reg[QW-1]))
    `ASSERT_NEXT(a_cfg_fb_write, cfg_valid && cfg_ready && (cfg_index == lmc_pkg::REG_FULL_BRIGHT),
        full_bright_reg == $past(cfg_data[0]))

endmodule
